@@ src/lpfr_pkg.sv @@
package lpfr_pkg;

  localparam int SIZE_W = 23;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 23'h7FFFFF;
  localparam logic [SIZE_W-1:0] MIN_SIZE = 23'd2;
  localparam int LONG_FLAG_BIT = 7;
  localparam logic [6:0] HIGH_MASK = 7'h7F;
  localparam logic [2:0] SHORT_LAST_IDX = 3'd3;
  localparam logic [2:0] LONG_LAST_IDX = 3'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        payload_byte;
    logic [15:0]       opcode;
    logic              last_of_frame;
    logic [SIZE_W-1:0] frame_size;
  } result_t;

  typedef struct packed {
    logic valid;
    logic halted;
  } status_t;

endpackage

@@ src/lpfr_if.sv @@
interface lpfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface lpfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] opcode;
  logic        last_of_frame;
  logic [22:0] frame_size;

  modport source (output valid, output result_kind, output payload_byte, output opcode,
                  output last_of_frame, output frame_size, input ready);
  modport sink (input valid, input result_kind, input payload_byte, input opcode,
                input last_of_frame, input frame_size, output ready);
endinterface

@@ src/length_prefixed_frame_reader.sv @@
// Channel   Direction  Payload
// stream    in         in_byte, chunk_end
// result    out        result_kind, payload_byte, opcode, last_of_frame, frame_size
// cfg       in         cfg_wen, cfg_wdata (max_frame_size)
//
// One byte is taken per cycle while stream.ready is high; its result, if any, is registered in the output buffer.
// The header and payload counters update in the same cycle as the transfer.
// A two-entry output buffer lets stream stay ready while a result stall holds only one entry.
// Reset is synchronous; after a bad size all bytes are dropped until reset.
module length_prefixed_frame_reader import lpfr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [SIZE_W-1:0]   cfg_wdata,
  lpfr_in_if.sink             stream,
  lpfr_out_if.source          result
);

  status_t st;
  result_t res;
  result_t out_data;
  logic    take;
  logic    can_push;

  assign take         = stream.valid && stream.ready;
  assign stream.ready = can_push;

  lpfr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .in_byte   (stream.in_byte),
    .status    (st),
    .res       (res)
  );

  lpfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (st.valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  assign result.result_kind   = out_data.kind;
  assign result.payload_byte  = out_data.payload_byte;
  assign result.opcode        = out_data.opcode;
  assign result.last_of_frame = out_data.last_of_frame;
  assign result.frame_size    = out_data.frame_size;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> stream.ready) else $error("stream stalled with empty output");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind == KIND_ERROR |-> result.last_of_frame)
    else $error("error result without last_of_frame");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind != KIND_PAYLOAD |-> result.payload_byte == 8'd0)
    else $error("nonzero byte on a non-payload result");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    st.halted |-> !st.valid) else $error("result produced after halt");

endmodule

@@ src/lpfr_parse.sv @@
module lpfr_parse import lpfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              take,
  input  logic [7:0]        in_byte,
  output status_t           status,
  output result_t           res
);

  logic [SIZE_W-1:0] max_frame_size;
  logic [7:0]        header_store [4];
  logic [2:0]        header_count;
  logic              long_header;
  logic [15:0]       frame_opcode;
  logic [SIZE_W-1:0] payload_left;
  logic [SIZE_W-1:0] decoded_size;
  logic              halted;

  logic [2:0]        header_count_next;
  logic              long_header_next;
  logic [15:0]       frame_opcode_next;
  logic [SIZE_W-1:0] payload_left_next;
  logic [SIZE_W-1:0] decoded_size_next;
  logic              halted_next;
  logic              store_en;
  logic              produce;
  logic              long_now;
  logic [2:0]        last_idx;
  logic [SIZE_W-1:0] size_dec;
  logic [15:0]       opcode_dec;

  always_comb begin
    header_count_next = header_count;
    long_header_next  = long_header;
    frame_opcode_next = frame_opcode;
    payload_left_next = payload_left;
    decoded_size_next = decoded_size;
    halted_next       = halted;
    store_en          = 1'b0;
    produce           = 1'b0;
    long_now          = (header_count == 3'd0) ? in_byte[LONG_FLAG_BIT] : long_header;
    last_idx          = long_now ? LONG_LAST_IDX : SHORT_LAST_IDX;
    size_dec          = long_now ? {header_store[0][6:0] & HIGH_MASK, header_store[1],
                                    header_store[2]}
                                 : {7'd0, header_store[0], header_store[1]};
    opcode_dec        = long_now ? {in_byte, header_store[3]} : {in_byte, header_store[2]};
    res.kind          = KIND_PAYLOAD;
    res.payload_byte  = 8'd0;
    res.last_of_frame = 1'b1;

    if (halted) begin
      produce = 1'b0;
    end else if (payload_left != '0) begin
      payload_left_next = payload_left - SIZE_W'(1);
      produce           = 1'b1;
      res.payload_byte  = in_byte;
      res.last_of_frame = (payload_left == SIZE_W'(1));
    end else if (header_count < last_idx) begin
      long_header_next  = long_now;
      store_en          = 1'b1;
      header_count_next = header_count + 3'd1;
    end else begin
      header_count_next = 3'd0;
      frame_opcode_next = opcode_dec;
      decoded_size_next = size_dec;
      produce           = 1'b1;
      if (size_dec < MIN_SIZE || size_dec > max_frame_size) begin
        halted_next = 1'b1;
        res.kind    = KIND_ERROR;
      end else begin
        payload_left_next = size_dec - MIN_SIZE;
        if (size_dec == MIN_SIZE) begin
          res.kind = KIND_EMPTY;
        end else begin
          produce = 1'b0;
        end
      end
    end

    res.opcode     = frame_opcode_next;
    res.frame_size = decoded_size_next;
    status.valid   = take && produce;
    status.halted  = halted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_size <= SIZE_MAX;
      header_count   <= 3'd0;
      long_header    <= 1'b0;
      frame_opcode   <= 16'd0;
      payload_left   <= '0;
      decoded_size   <= '0;
      halted         <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        header_store[i] <= 8'd0;
      end
    end else begin
      if (cfg_wen) begin
        max_frame_size <= cfg_wdata;
      end
      if (take) begin
        header_count <= header_count_next;
        long_header  <= long_header_next;
        frame_opcode <= frame_opcode_next;
        payload_left <= payload_left_next;
        decoded_size <= decoded_size_next;
        halted       <= halted_next;
        if (store_en) begin
          header_store[header_count[1:0]] <= in_byte;
        end
      end
    end
  end

endmodule

@@ src/lpfr_skid.sv @@
module lpfr_skid import lpfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule
